// ===== design/cmm_pkg.sv =====
package cmm_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_TURN_COUNT     = 3'd0;
  localparam logic [2:0] REG_FORWARD_COUNT  = 3'd1;
  localparam logic [2:0] REG_BASE_LEFT      = 3'd2;
  localparam logic [2:0] REG_BASE_RIGHT     = 3'd3;
  localparam logic [2:0] REG_STOP_FRONT     = 3'd4;
  localparam logic [2:0] REG_CLEAR_FRONT    = 3'd5;
  localparam logic [2:0] REG_SIDE_NEAR      = 3'd6;
  localparam logic [2:0] REG_DIAG_NEAR      = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [9:0] RST_TURN_COUNT    = 10'd153;
  localparam logic [9:0] RST_FORWARD_COUNT = 10'd430;
  localparam logic [6:0] RST_BASE_LEFT     = 7'd30;
  localparam logic [6:0] RST_BASE_RIGHT    = 7'd35;
  localparam logic [7:0] RST_STOP_FRONT    = 8'd30;
  localparam logic [7:0] RST_CLEAR_FRONT   = 8'd40;
  localparam logic [7:0] RST_SIDE_NEAR     = 8'd27;
  localparam logic [7:0] RST_DIAG_NEAR     = 8'd32;

  localparam logic [8:0] SIDE_TRIM = 9'd6;
  localparam logic [8:0] DIAG_TRIM = 9'd9;

  localparam logic signed [12:0] SPEED_MAX = 13'sd2047;
  localparam logic signed [12:0] SPEED_MIN = -13'sd2048;

  // Decoupling queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic signed [11:0] speed_t;
  typedef logic signed [12:0] wide_speed_t;

  typedef struct packed {
    logic [9:0] turn_count;
    logic [9:0] forward_count;
    logic [6:0] base_left_speed;
    logic [6:0] base_right_speed;
    logic [7:0] stop_front_limit;
    logic [7:0] clear_front_limit;
    logic [7:0] side_near_limit;
    logic [7:0] diagonal_near_limit;
  } cfg_t;

  // One classified tick, as handed from the front to the back
  typedef struct packed {
    logic [1:0]        target;
    logic signed [10:0] diff;        // left encoder minus right encoder
    logic              turn_reached;
    logic              stop;
    logic              trim_en;
    logic signed [8:0] left_set;
    logic signed [8:0] right_set;
  } item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

  function automatic speed_t sat12(input wide_speed_t v);
    speed_t r;
    if (v > SPEED_MAX) begin
      r = SPEED_MAX[11:0];
    end else if (v < SPEED_MIN) begin
      r = SPEED_MIN[11:0];
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

// ===== design/cmm_if.sv =====
interface cmm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] target_heading;
  logic [9:0] left_encoder;
  logic [9:0] right_encoder;
  logic [7:0] front_distance;
  logic [7:0] left_distance;
  logic [7:0] right_distance;
  logic [7:0] front_left_distance;
  logic [7:0] front_right_distance;

  modport source (
    output valid, target_heading, left_encoder, right_encoder, front_distance,
           left_distance, right_distance, front_left_distance, front_right_distance,
    input  ready
  );
  modport sink (
    input  valid, target_heading, left_encoder, right_encoder, front_distance,
           left_distance, right_distance, front_left_distance, front_right_distance,
    output ready
  );
endinterface

interface cmm_out_if;
  logic              valid;
  logic              ready;
  logic signed [11:0] left_drive;
  logic signed [11:0] right_drive;
  logic [1:0]        current_heading;
  logic              instruction_done;

  modport source (
    output valid, left_drive, right_drive, current_heading, instruction_done,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, current_heading, instruction_done,
    output ready
  );
endinterface

// ===== design/cmm_front.sv =====
module cmm_front (
  cmm_in_if.sink          in_ch,
  input  cmm_pkg::cfg_t   cfg,
  input  cmm_pkg::q_stat_t q_stat,
  output logic            push,
  output cmm_pkg::item_t  item
);
  import cmm_pkg::*;

  logic [8:0] left_trim;
  logic [8:0] right_trim;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  // Trim on the right wheel comes from the left sensors and vice versa
  always_comb begin
    if (in_ch.left_distance < cfg.side_near_limit) begin
      right_trim = SIDE_TRIM;
    end else if (in_ch.front_left_distance < cfg.diagonal_near_limit) begin
      right_trim = DIAG_TRIM;
    end else begin
      right_trim = 9'd0;
    end
    if (in_ch.right_distance < cfg.side_near_limit) begin
      left_trim = SIDE_TRIM;
    end else if (in_ch.front_right_distance < cfg.diagonal_near_limit) begin
      left_trim = DIAG_TRIM;
    end else begin
      left_trim = 9'd0;
    end
  end

  always_comb begin
    item.target       = in_ch.target_heading;
    item.diff         = $signed({1'b0, in_ch.left_encoder}) -
                        $signed({1'b0, in_ch.right_encoder});
    item.turn_reached = (in_ch.left_encoder > cfg.turn_count) &&
                        (in_ch.right_encoder > cfg.turn_count);
    item.stop         = (in_ch.front_distance < cfg.stop_front_limit) ||
                        ((in_ch.left_encoder > cfg.forward_count) &&
                         (in_ch.right_encoder > cfg.forward_count));
    item.trim_en      = in_ch.front_distance > cfg.clear_front_limit;
    item.left_set     = $signed({2'b00, cfg.base_left_speed} - left_trim);
    item.right_set    = $signed({2'b00, cfg.base_right_speed} - right_trim);
  end

endmodule

// ===== design/cmm_queue.sv =====
module cmm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cmm_pkg::item_t   push_item,
  input  logic             pop,
  output cmm_pkg::item_t   head_item,
  output cmm_pkg::q_stat_t q_stat
);
  import cmm_pkg::*;

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head_item    = mem[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

// ===== design/cmm_back.sv =====
module cmm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cmm_pkg::cfg_t    cfg,
  input  cmm_pkg::item_t   head_item,
  input  cmm_pkg::q_stat_t q_stat,
  output logic             pop,
  cmm_out_if.source        out_ch
);
  import cmm_pkg::*;

  logic [1:0] heading_r, heading_nxt;
  logic       fwd_done_r, fwd_done_nxt;
  speed_t     left_speed_r, left_speed_nxt;
  speed_t     right_speed_r, right_speed_nxt;
  logic       done_nxt;
  logic       out_valid_r, out_valid_nxt;
  speed_t     out_left_r, out_right_r;
  logic [1:0] out_heading_r;
  logic       out_done_r;

  logic              cw;
  wide_speed_t       diff_w, bl_w, br_w, rs_base;
  speed_t            ls_trim;

  // Take the next tick whenever the output register is free or draining
  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    diff_w  = {{2{head_item.diff[10]}}, head_item.diff};
    bl_w    = {6'b0, cfg.base_left_speed};
    br_w    = {6'b0, cfg.base_right_speed};
    cw      = (heading_r + 2'd1) == head_item.target;
    rs_base = head_item.trim_en ? {{4{head_item.right_set[8]}}, head_item.right_set}
                                : {right_speed_r[11], right_speed_r};
    ls_trim = head_item.trim_en ? {{3{head_item.left_set[8]}}, head_item.left_set}
                                : left_speed_r;

    heading_nxt     = heading_r;
    fwd_done_nxt    = fwd_done_r;
    left_speed_nxt  = left_speed_r;
    right_speed_nxt = right_speed_r;
    done_nxt        = 1'b0;

    if (heading_r != head_item.target) begin
      if (head_item.turn_reached) begin
        heading_nxt     = cw ? heading_r + 2'd1 : heading_r - 2'd1;
        left_speed_nxt  = '0;
        right_speed_nxt = '0;
      end else if (cw) begin
        left_speed_nxt  = sat12(bl_w - diff_w);
        right_speed_nxt = sat12(-br_w - diff_w);
      end else begin
        left_speed_nxt  = sat12(diff_w - bl_w);
        right_speed_nxt = sat12(br_w + diff_w);
      end
    end else if (fwd_done_r) begin
      done_nxt     = 1'b1;
      fwd_done_nxt = 1'b0;
    end else if (head_item.stop) begin
      left_speed_nxt  = '0;
      right_speed_nxt = '0;
      fwd_done_nxt    = 1'b1;
    end else if (left_speed_r == '0) begin
      left_speed_nxt  = {5'b0, cfg.base_left_speed};
      right_speed_nxt = {5'b0, cfg.base_right_speed};
    end else begin
      left_speed_nxt  = ls_trim;
      right_speed_nxt = sat12(rs_base + diff_w);
    end

    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r     <= '0;
      fwd_done_r    <= 1'b0;
      left_speed_r  <= '0;
      right_speed_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        heading_r     <= heading_nxt;
        fwd_done_r    <= fwd_done_nxt;
        left_speed_r  <= left_speed_nxt;
        right_speed_r <= right_speed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_left_r    <= left_speed_nxt;
      out_right_r   <= right_speed_nxt;
      out_heading_r <= heading_nxt;
      out_done_r    <= done_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.left_drive       = out_left_r;
  assign out_ch.right_drive      = out_right_r;
  assign out_ch.current_heading  = out_heading_r;
  assign out_ch.instruction_done = out_done_r;

endmodule

// ===== design/cell_move_motor_controller_top.sv =====
// Channel  | Dir | Handshake        | Payload
// in_ch    | in  | valid/ready      | target heading, two encoders, five distances
// out_ch   | out | valid/ready      | left/right drive, heading, instruction done
// cfg_*    | in  | cfg_we only      | cfg_index selects register, cfg_wdata value
//
// One tick per clock sustained while out_ch is ready; a tick's result passes
// classification into the two-entry queue, then the state update into the output
// register, and is held on out_ch until it transfers. Reset is synchronous and
// restores state, queue pointers, cfg and output valid, but not the output payload
// or queue entries. Input and output stall on their own: the queue keeps taking
// ticks while a result waits on out_ch, until both of its entries are held.
module cell_move_motor_controller_top (
  input  logic                            clk,
  input  logic                            rst_n,
  cmm_in_if.sink                          in_ch,
  cmm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [cmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cmm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cmm_pkg::*;

  cfg_t    cfg_r;
  item_t   push_item, head_item;
  q_stat_t q_stat;
  logic    push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.turn_count          <= RST_TURN_COUNT;
      cfg_r.forward_count       <= RST_FORWARD_COUNT;
      cfg_r.base_left_speed     <= RST_BASE_LEFT;
      cfg_r.base_right_speed    <= RST_BASE_RIGHT;
      cfg_r.stop_front_limit    <= RST_STOP_FRONT;
      cfg_r.clear_front_limit   <= RST_CLEAR_FRONT;
      cfg_r.side_near_limit     <= RST_SIDE_NEAR;
      cfg_r.diagonal_near_limit <= RST_DIAG_NEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TURN_COUNT:    cfg_r.turn_count          <= cfg_wdata;
        REG_FORWARD_COUNT: cfg_r.forward_count       <= cfg_wdata;
        REG_BASE_LEFT:     cfg_r.base_left_speed     <= cfg_wdata[6:0];
        REG_BASE_RIGHT:    cfg_r.base_right_speed    <= cfg_wdata[6:0];
        REG_STOP_FRONT:    cfg_r.stop_front_limit    <= cfg_wdata[7:0];
        REG_CLEAR_FRONT:   cfg_r.clear_front_limit   <= cfg_wdata[7:0];
        REG_SIDE_NEAR:     cfg_r.side_near_limit     <= cfg_wdata[7:0];
        REG_DIAG_NEAR:     cfg_r.diagonal_near_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  cmm_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .push   (push),
    .item   (push_item)
  );

  cmm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  cmm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_item (head_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // A result only appears after a tick left the queue
  a_valid_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(pop))
    else $error("result valid without a queue pop");

  // Hold a waiting result and its payload until it transfers
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable({out_ch.left_drive, out_ch.right_drive,
                                out_ch.current_heading, out_ch.instruction_done})))
    else $error("waiting result changed before transfer");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |=> !(push && !pop) || !q_stat.full)
    else $error("queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_stat.count != '0) && (!out_ch.valid || out_ch.ready))
    else $error("pop from empty queue or into a held result");

endmodule
